// File: hdl/mpc_pkg.sv
// mpc_pkg: shared types, constants and register offsets for the memory protection controller
// no dependencies
package mpc_pkg;

    localparam int LUT_DEPTH_DEF = 64;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [9:0] REG_CTRL      = 10'h000;
    localparam logic [9:0] REG_BLK_MAX   = 10'h004;
    localparam logic [9:0] REG_BLK_CFG   = 10'h005;
    localparam logic [9:0] REG_BLK_IDX   = 10'h006;
    localparam logic [9:0] REG_BLK_LUT   = 10'h007;
    localparam logic [9:0] REG_IRQ_STAT  = 10'h008;
    localparam logic [9:0] REG_INT_CLEAR = 10'h009;
    localparam logic [9:0] REG_INT_EN    = 10'h00a;
    localparam logic [9:0] REG_INT_INFO1 = 10'h00b;
    localparam logic [9:0] REG_INT_INFO2 = 10'h00c;
    localparam logic [9:0] REG_INT_SET   = 10'h00d;
    localparam logic [9:0] REG_ID_FIRST  = 10'h3f4;

    localparam logic CFG_BLK_SIZE  = 1'b0;
    localparam logic CFG_LUT_WORDS = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_EXEC, t_ST_MOD, t_ST_DONE
    } t_state;

    // request to the shared remainder unit, and its answer
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [10:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic        done;
        logic [31:0] remainder;
    } t_mod_rsp;

    function automatic logic [7:0] id_byte(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0:    r = 8'h04;
            4'd4:    r = 8'h60;
            4'd5:    r = 8'hb8;
            4'd6:    r = 8'h1b;
            4'd8:    r = 8'h0d;
            4'd9:    r = 8'hf0;
            4'd10:   r = 8'h05;
            4'd11:   r = 8'hb1;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/mpc_mod_unit.sv
// mpc_mod_unit: restoring remainder unit, one quotient bit per cycle
// depends on mpc_pkg
module mpc_mod_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mpc_pkg::t_mod_req i_req,
    output mpc_pkg::t_mod_rsp o_rsp
);
    logic [31:0] r_dvd;
    logic [31:0] n_dvd;
    logic [32:0] r_rem;
    logic [32:0] n_rem;
    logic [10:0] r_dvs;
    logic [5:0]  r_cnt;
    logic [5:0]  n_cnt;
    logic        r_busy;
    logic        n_busy;
    logic        r_done;
    logic [32:0] w_shift;

    always_comb begin
        w_shift = {r_rem[31:0], r_dvd[31]};
        n_dvd   = {r_dvd[30:0], 1'b0};
        n_rem   = (w_shift >= {22'd0, r_dvs}) ? w_shift - {22'd0, r_dvs} : w_shift;
        n_cnt   = r_cnt - 6'd1;
        n_busy  = (r_cnt != 6'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd  <= n_dvd;
                r_rem  <= n_rem;
                r_cnt  <= n_cnt;
                r_busy <= n_busy;
                r_done <= !n_busy;
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[31:0];

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("remainder done while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {22'd0, r_dvs})) else $error("remainder not reduced");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_req.start) |-> (r_cnt != 6'd0)) else $error("count underflow");
endmodule

// File: hdl/memory_protection_controller_top.sv
// memory_protection_controller_top: block-granular security gate with register window
// depends on mpc_pkg and mpc_mod_unit
//
//  channel | direction | handshake                 | payload
//  input   | in        | i_valid / o_stall         | cmd, reg_offset, size_bytes, write_data, ...
//  output  | out       | o_valid / i_stall         | read_data, pass, bus_error, range_error, irq
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// a transaction steps through accept with table read, execute, and the result register;
// the result shows in the done state, after the execute step
// an index write runs the shared remainder unit before the result shows
// a table count write stalls input while the index is reduced
// synchronous active-low reset; table words use valid bits, invalid words read zero
// input is stalled from acceptance until the result is taken, and while a config write waits
module memory_protection_controller_top #(
    parameter int LUT_DEPTH = mpc_pkg::LUT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [11:0] i_reg_offset,
    input  logic [2:0]  i_size_bytes,
    input  logic [31:0] i_write_data,
    input  logic        i_secure,
    input  logic        i_unspecified,
    input  logic [31:0] i_mem_addr,
    input  logic [15:0] i_requester,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_pass,
    output logic        o_bus_error,
    output logic        o_range_error,
    output logic        o_irq,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int IW = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1;
    localparam int CW = $clog2(LUT_DEPTH + 1);

    mpc_pkg::t_state r_state, n_state;

    // captured transaction
    logic [1:0]  r_cmd;
    logic [11:0] r_off;
    logic [2:0]  r_sz;
    logic [31:0] r_wdata;
    logic        r_sec, r_unsp;
    logic [31:0] r_addr;
    logic [15:0] r_req;

    // architectural state
    logic [3:0]  r_bsize;
    logic [6:0]  r_words;
    logic [2:0]  r_ctrl;
    logic [IW-1:0] r_idx;
    logic [31:0] r_lut [LUT_DEPTH];
    logic [LUT_DEPTH-1:0] r_lut_vld;
    logic        r_irq_st, r_irq_en;
    logic [31:0] r_faddr;
    logic [17:0] r_finfo;

    // table word read at acceptance
    logic [31:0] r_lut_q;
    logic        r_lut_qv;

    // result register
    logic        r_ovalid;
    logic [31:0] r_rd;
    logic        r_pass, r_berr, r_rerr;

    // remainder unit
    mpc_pkg::t_mod_req w_mreq;
    mpc_pkg::t_mod_rsp w_mrsp;
    logic        r_mod_go;
    logic [31:0] r_mod_dvd;
    logic        r_cfg_mod;

    mpc_mod_unit u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_mreq),
        .o_rsp  (w_mrsp)
    );

    // effective table count
    logic [CW-1:0] w_max;
    always_comb begin
        if (r_words == 7'd0)
            w_max = CW'(1);
        else if ({25'd0, r_words} > 32'(LUT_DEPTH))
            w_max = CW'(LUT_DEPTH);
        else
            w_max = CW'(r_words);
    end

    assign w_mreq.start    = r_mod_go;
    assign w_mreq.dividend = r_mod_dvd;
    assign w_mreq.divisor  = 11'(w_max);

    // table read address: the block word for a check, the index otherwise
    logic          w_in_acc;
    logic [31:0]   w_in_blk;
    logic [IW-1:0] w_lut_ra;
    always_comb begin
        w_in_acc = (r_state == mpc_pkg::t_ST_IDLE) && i_valid && !o_stall;
        w_in_blk = i_mem_addr >> (5'(r_bsize) + 5'd5);
        w_lut_ra = (i_cmd == mpc_pkg::CMD_CHECK) ? IW'(w_in_blk[31:5]) : r_idx;
    end

    // decode of the held transaction
    logic [2:0]  w_sz;
    logic [9:0]  w_wrd;
    logic [4:0]  w_sh;
    logic [31:0] w_mask, w_cur, w_ctrlv, w_r, w_rd, w_v, w_old;
    logic        w_nsblk, w_lock_hit;
    logic [31:0] w_idx32;

    always_comb begin
        w_sz    = (r_sz == 3'd1 || r_sz == 3'd2) ? r_sz : 3'd4;
        w_wrd   = r_off[11:2];
        w_sh    = {r_off[1:0], 3'b000};
        case (w_sz)
            3'd1:    w_mask = 32'h0000_00ff << w_sh;
            3'd2:    w_mask = 32'h0000_ffff << w_sh;
            default: w_mask = 32'hffff_ffff;
        endcase
        w_cur   = r_lut_qv ? r_lut_q : 32'd0;
        w_ctrlv = {r_ctrl[2], 22'd0, r_ctrl[1], 3'd0, r_ctrl[0], 4'd0};
        w_idx32 = 32'(r_idx);
        w_nsblk = !r_sec && (w_wrd < mpc_pkg::REG_ID_FIRST);
        case (w_wrd)
            mpc_pkg::REG_CTRL:      w_r = w_ctrlv;
            mpc_pkg::REG_BLK_MAX:   w_r = 32'(w_max) - 32'd1;
            mpc_pkg::REG_BLK_CFG:   w_r = {28'd0, r_bsize};
            mpc_pkg::REG_BLK_IDX:   w_r = w_idx32;
            mpc_pkg::REG_BLK_LUT:   w_r = w_cur;
            mpc_pkg::REG_IRQ_STAT:  w_r = {31'd0, r_irq_st};
            mpc_pkg::REG_INT_EN:    w_r = {31'd0, r_irq_en};
            mpc_pkg::REG_INT_INFO1: w_r = r_faddr;
            mpc_pkg::REG_INT_INFO2: w_r = {14'd0, r_finfo};
            default:
                if (w_wrd >= mpc_pkg::REG_ID_FIRST)
                    w_r = {24'd0, mpc_pkg::id_byte(4'(w_wrd - mpc_pkg::REG_ID_FIRST))};
                else
                    w_r = 32'd0;
        endcase
        // full-word reads are never shifted, whatever the low offset bits
        if (w_nsblk)
            w_rd = 32'd0;
        else if (w_sz == 3'd4)
            w_rd = w_r;
        else
            w_rd = (w_r & w_mask) >> w_sh;
        case (w_wrd)
            mpc_pkg::REG_CTRL:    w_old = w_ctrlv;
            mpc_pkg::REG_BLK_IDX: w_old = w_idx32;
            mpc_pkg::REG_BLK_LUT: w_old = w_cur;
            default:              w_old = 32'd0;
        endcase
        w_v = (w_sz == 3'd4) ? r_wdata : ((w_old & ~w_mask) | ((r_wdata << w_sh) & w_mask));
        w_lock_hit = r_ctrl[2] && (w_wrd == mpc_pkg::REG_CTRL ||
            w_wrd == mpc_pkg::REG_BLK_LUT || w_wrd == mpc_pkg::REG_INT_EN);
    end

    // transaction check
    logic [31:0] w_blk;
    logic [26:0] w_word;
    logic        w_inr, w_bit, w_ns, w_pass;
    always_comb begin
        w_blk  = r_addr >> (5'(r_bsize) + 5'd5);
        w_word = w_blk[31:5];
        w_inr  = ({5'd0, w_word} < 32'(w_max));
        w_bit  = w_inr ? w_cur[w_blk[4:0]] : 1'b0;
        w_ns   = !(r_sec || r_unsp);
        w_pass = w_inr && (w_bit == w_ns);
    end

    // auto-increment: wrap by compare, next index never reaches the count
    logic          w_bump;
    logic [IW:0]   w_inc;
    logic [IW-1:0] w_inc_wr;
    always_comb begin
        w_bump   = (w_sz == 3'd4) && r_ctrl[1];
        w_inc    = {1'b0, r_idx} + (IW+1)'(1);
        w_inc_wr = ((CW > IW + 1 ? CW : IW + 1)'(w_inc) >= (CW > IW + 1 ? CW : IW + 1)'(w_max))
                   ? IW'(0) : IW'(w_inc);
    end

    // table write from the execute step
    logic w_lut_we;
    assign w_lut_we = (r_state == mpc_pkg::t_ST_EXEC) && (r_cmd == mpc_pkg::CMD_WRITE) &&
                      !w_nsblk && !w_lock_hit && (w_wrd == mpc_pkg::REG_BLK_LUT);

    // next state
    logic w_need_mod;
    assign w_need_mod = (r_cmd == mpc_pkg::CMD_WRITE) && !w_nsblk &&
                        (w_wrd == mpc_pkg::REG_BLK_IDX);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mpc_pkg::t_ST_IDLE: if (w_in_acc) n_state = mpc_pkg::t_ST_EXEC;
                else if (r_cfg_mod) n_state = mpc_pkg::t_ST_MOD;
            mpc_pkg::t_ST_EXEC: n_state = w_need_mod ? mpc_pkg::t_ST_MOD : mpc_pkg::t_ST_DONE;
            mpc_pkg::t_ST_MOD:  if (w_mrsp.done)
                n_state = r_cfg_mod ? mpc_pkg::t_ST_IDLE : mpc_pkg::t_ST_DONE;
            mpc_pkg::t_ST_DONE: if (!i_stall) n_state = mpc_pkg::t_ST_IDLE;
            default:            n_state = mpc_pkg::t_ST_IDLE;
        endcase
    end

    // outputs of the sequencer; a waiting config write holds off new input
    always_comb begin
        o_stall     = (r_state != mpc_pkg::t_ST_IDLE) || r_cfg_mod || i_cfg_valid;
        o_cfg_ready = (r_state == mpc_pkg::t_ST_IDLE) && !r_cfg_mod;
        o_valid     = r_ovalid;
    end

    assign o_read_data   = r_rd;
    assign o_pass        = r_pass;
    assign o_bus_error   = r_berr;
    assign o_range_error = r_rerr;
    assign o_irq         = r_irq_st & r_irq_en;

    // table memory: one registered read at acceptance, one write in execute
    always_ff @(posedge i_clk) begin
        if (w_lut_we) r_lut[r_idx] <= w_v;
        if (w_in_acc) r_lut_q <= r_lut[w_lut_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mpc_pkg::t_ST_IDLE;
            r_bsize   <= 4'd7;
            r_words   <= 7'd64;
            r_ctrl    <= 3'b010;
            r_idx     <= '0;
            r_lut_vld <= '0;
            r_lut_qv  <= 1'b0;
            r_irq_st  <= 1'b0;
            r_irq_en  <= 1'b1;
            r_faddr   <= '0;
            r_finfo   <= '0;
            r_ovalid  <= 1'b0;
            r_mod_go  <= 1'b0;
            r_cfg_mod <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mod_go <= 1'b0;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                mpc_pkg::t_ST_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        if (i_cfg_index == mpc_pkg::CFG_BLK_SIZE)
                            r_bsize <= i_cfg_data[3:0];
                        else begin
                            // count change: reduce index by the new count
                            r_words   <= i_cfg_data[6:0];
                            r_cfg_mod <= 1'b1;
                            r_mod_go  <= 1'b1;
                            r_mod_dvd <= 32'(r_idx);
                        end
                    end
                    if (w_in_acc) begin
                        r_cmd    <= i_cmd;
                        r_off    <= i_reg_offset;
                        r_sz     <= i_size_bytes;
                        r_wdata  <= i_write_data;
                        r_sec    <= i_secure;
                        r_unsp   <= i_unspecified;
                        r_addr   <= i_mem_addr;
                        r_req    <= i_requester;
                        r_lut_qv <= r_lut_vld[w_lut_ra];
                    end
                end
                mpc_pkg::t_ST_EXEC: begin
                    r_rd   <= 32'd0;
                    r_pass <= 1'b0;
                    r_berr <= 1'b0;
                    r_rerr <= 1'b0;
                    case (r_cmd)
                        mpc_pkg::CMD_READ: begin
                            r_rd <= w_rd;
                            if (!w_nsblk && w_wrd == mpc_pkg::REG_BLK_LUT && w_bump)
                                r_idx <= w_inc_wr;
                        end
                        mpc_pkg::CMD_WRITE: begin
                            if (!w_nsblk && !w_lock_hit) begin
                                case (w_wrd)
                                    mpc_pkg::REG_CTRL:
                                        r_ctrl <= {w_v[31], w_v[8], w_v[4]};
                                    mpc_pkg::REG_BLK_IDX: begin
                                        r_mod_go  <= 1'b1;
                                        r_mod_dvd <= w_v;
                                    end
                                    mpc_pkg::REG_BLK_LUT: begin
                                        r_lut_vld[r_idx] <= 1'b1;
                                        if (w_bump) r_idx <= w_inc_wr;
                                    end
                                    mpc_pkg::REG_INT_CLEAR: if (w_v[0]) r_irq_st <= 1'b0;
                                    mpc_pkg::REG_INT_EN:    r_irq_en <= w_v[0];
                                    mpc_pkg::REG_INT_SET:   if (w_v[0]) r_irq_st <= 1'b1;
                                    default: ;
                                endcase
                            end else if (!w_nsblk && w_wrd == mpc_pkg::REG_BLK_IDX) begin
                                r_mod_go  <= 1'b1;
                                r_mod_dvd <= w_v;
                            end
                        end
                        mpc_pkg::CMD_CHECK: begin
                            r_pass <= w_pass;
                            r_rerr <= !w_inr;
                            if (!w_pass) begin
                                r_berr <= r_ctrl[0];
                                if (!r_irq_st) begin
                                    r_faddr  <= r_addr;
                                    r_finfo  <= {w_bit, !r_sec, r_req};
                                    r_irq_st <= 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (!w_need_mod) r_ovalid <= 1'b1;
                end
                mpc_pkg::t_ST_MOD: begin
                    if (w_mrsp.done) begin
                        r_idx <= IW'(w_mrsp.remainder);
                        if (r_cfg_mod) r_cfg_mod <= 1'b0;
                        else r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    a_out_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == mpc_pkg::t_ST_DONE)) else $error("result outside done");
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpc_pkg::t_ST_IDLE && !r_cfg_mod) |-> (32'(r_idx) < 32'(w_max)))
        else $error("index beyond table count");
    a_pass_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_pass && (o_bus_error || o_range_error)))
        else $error("passed transaction flagged");
    a_fault_sets_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpc_pkg::t_ST_EXEC && r_cmd == mpc_pkg::CMD_CHECK && !w_pass) |=> r_irq_st)
        else $error("fault did not raise status");
endmodule
